// ----- src/series_sine_cosine_unit_assert.svh -----
// Assertion macros for the series sine and cosine unit.
// Used by the top level only; compiled out when SYNTH is defined.
`ifndef SERIES_SINE_COSINE_UNIT_ASSERT_SVH
`define SERIES_SINE_COSINE_UNIT_ASSERT_SVH
`ifndef SYNTH
// Clocked property that is switched off while reset is high.
`define SSC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("series_sine_cosine_unit: assertion failed");
// Clocked property that is checked at every edge, reset included.
`define SSC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("series_sine_cosine_unit: assertion failed");
`else
`define SSC_ASSERT(lbl, clk, rst, prop)
`define SSC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- src/ssc_pkg.sv -----
// Shared types, constants and helper functions of the series sine and cosine unit.
// Depends on nothing; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package ssc_pkg;

   // Field and internal word widths.
   localparam int ANG_W     = 32;
   localparam int OUT_W     = 32;
   localparam int ANG_FRAC  = 24;
   localparam int FRAC_W    = 48;
   localparam int X_W       = 56;
   localparam int HALF_W    = X_W / 2;
   localparam int PROD_W    = 2 * X_W;
   localparam int ACC_W     = 64;
   localparam int QUO_W     = 64;
   localparam int OUT_SHIFT = FRAC_W - (OUT_W - 2);

   // Series length and the widths that follow from it.
   localparam int MAX_TERMS = 16;
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);
   localparam int N_MAX     = MAX_TERMS - 1;
   localparam int DIV_MAX   = (2 * N_MAX) * (2 * N_MAX + 1);
   localparam int DIV_W     = $clog2(DIV_MAX + 1);

   // Sequencing of the multi-cycle operations.
   localparam int RED_STEPS = 5;
   localparam int MUL_STEPS = 4;
   localparam int DIV_BITS  = 8;
   localparam int DIV_STEPS = QUO_W / DIV_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Fixed-point constants in Q48.
   localparam logic [X_W-1:0]   TWO_PI_Q48 = 56'h6487ED5110B46;
   localparam logic [X_W-1:0]   ONE_Q48    = 56'h1000000000000;
   localparam logic [ACC_W-1:0] ROUND_Q48  = 64'h0000000000020000;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_REDUCE,
      S_FIXUP,
      S_SQUARE,
      S_INIT,
      S_CHECK,
      S_MUL,
      S_DIV,
      S_ACCUM,
      S_FINISH
   } ctrl_state_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_REDUCE,
      OP_FIXUP,
      OP_MUL_SQ,
      OP_INIT,
      OP_CHECK,
      OP_MUL_TERM,
      OP_DIV,
      OP_ACCUM,
      OP_FINISH
   } dp_op_type;

   // Command from controller to datapath.
   typedef struct packed {
      dp_op_type         op;
      logic [STEP_W-1:0] step;
   } dp_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic loop_go;
      logic out_free;
   } dp_stat_type;

   // Factorial pair for step n: (2n)(2n+1) for sine, (2n-1)(2n) for cosine.
   function automatic logic [DIV_W-1:0] pair_divisor(input logic [CNT_W-1:0] n,
                                                     input logic is_cos);
      logic [DIV_W-1:0] two_n;
      two_n = DIV_W'({n, 1'b0});
      if (is_cos) begin
         return two_n * (two_n - DIV_W'(1));
      end
      return two_n * (two_n + DIV_W'(1));
   endfunction

endpackage

// ----- src/series_sine_cosine_unit.sv -----
// Top level of the series sine and cosine unit: controller plus datapath.
// Depends on ssc_pkg, ssc_ctrl, ssc_datapath and series_sine_cosine_unit_assert.svh.
//
// Usage: a request carries req_type (0 sine, 1 cosine) and req_angle in radians,
// Q8.24. It is taken at a clock edge where req_valid is high and req_stall low.
// The angle is reduced into [0, 2*pi) by a five-step restoring subtraction, then
// x^2 is formed in four multiply steps on the shared 28x28 multiplier. Each series
// term takes divisor setup, four multiply steps, eight long-division steps (eight
// quotient bits a cycle) and the accumulate. At most 16 terms are summed; the
// series also stops once a term falls below the output resolution. One request
// is in work at a time; req_stall is low only when the unit is idle, so a new
// request is taken the cycle after the result is registered.
// The result, rsp_value in Q2.30 with saturation, sits in an output register and
// is handed over at an edge where rsp_valid is high and rsp_stall low. While the
// receiver stalls, the result holds and the next request may already be worked
// on; the unit then waits at its final rounding step until the register frees.
// Synchronous reset returns the controller to idle and empties the output.
`timescale 1ns / 1ps
`include "series_sine_cosine_unit_assert.svh"
module series_sine_cosine_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic signed [ssc_pkg::ANG_W-1:0]  req_angle,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ssc_pkg::OUT_W-1:0]  rsp_value
);
   import ssc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer.
   ssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Arithmetic and output register.
   ssc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_type  (req_type),
      .req_angle (req_angle),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_value (rsp_value)
   );

   // A taken request makes the unit busy on the next cycle.
   `SSC_ASSERT(a_accept_busy, clock, reset, (req_valid && !req_stall) |=> req_stall)
   // The final step never overwrites a result that is still stalled.
   `SSC_ASSERT(a_hold_result, clock, reset, (cmd.op == OP_FINISH && !stat.out_free) |=> $stable(rsp_value))
   // Reset leaves the output register empty.
   `SSC_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid)

endmodule

// ----- src/ssc_ctrl.sv -----
// Controller of the series sine and cosine unit: sequences reduction, squaring,
// the series loop and rounding. Depends on ssc_pkg.
`timescale 1ns / 1ps
module ssc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ssc_pkg::dp_stat_type stat,
   output ssc_pkg::dp_cmd_type  cmd
);
   import ssc_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and step count.
   always_comb begin
      state_in = state_ff;
      step_in  = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_REDUCE;
         end
         S_REDUCE: begin
            if (step_ff == STEP_W'(RED_STEPS - 1)) begin
               state_in = S_FIXUP;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_FIXUP: state_in = S_SQUARE;
         S_SQUARE: begin
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               state_in = S_INIT;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_INIT: state_in = S_CHECK;
         S_CHECK: begin
            state_in = stat.loop_go ? S_MUL : S_FINISH;
         end
         S_MUL: begin
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               state_in = S_DIV;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_ACCUM;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_ACCUM: state_in = S_CHECK;
         S_FINISH: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath and the request stall.
   always_comb begin
      cmd.step  = step_ff;
      cmd.op    = OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.op    = req_valid ? OP_LOAD : OP_NONE;
         end
         S_REDUCE: cmd.op = OP_REDUCE;
         S_FIXUP:  cmd.op = OP_FIXUP;
         S_SQUARE: cmd.op = OP_MUL_SQ;
         S_INIT:   cmd.op = OP_INIT;
         S_CHECK:  cmd.op = OP_CHECK;
         S_MUL:    cmd.op = OP_MUL_TERM;
         S_DIV:    cmd.op = OP_DIV;
         S_ACCUM:  cmd.op = OP_ACCUM;
         S_FINISH: cmd.op = OP_FINISH;
         default:  cmd.op = OP_NONE;
      endcase
   end

endmodule

// ----- src/ssc_datapath.sv -----
// Datapath of the series sine and cosine unit: angle reduction, shared 28x28
// multiplier, small-divisor long division, accumulator and output register.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
module ssc_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  ssc_pkg::dp_cmd_type        cmd,
   output ssc_pkg::dp_stat_type       stat,
   input  logic                       req_type,
   input  logic signed [ssc_pkg::ANG_W-1:0] req_angle,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [ssc_pkg::OUT_W-1:0] rsp_value
);
   import ssc_pkg::*;

   logic                  is_cos_ff, is_cos_in;
   logic                  neg_ff, neg_in;
   logic [X_W-1:0]        x_ff, x_in;
   logic [X_W-1:0]        x2_ff, x2_in;
   logic [X_W-1:0]        term_ff, term_in;
   logic                  term_neg_ff, term_neg_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic [DIV_W-1:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]      div_ff, div_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_value_ff, rsp_value_in;

   logic                  out_free;
   logic                  loop_go;
   logic [ANG_W-1:0]      ang_u;
   logic [ANG_W-1:0]      mag;
   logic [X_W-1:0]        red_sub;
   logic [2:0]            red_shift;
   logic [X_W-1:0]        op_a, op_b;
   logic [HALF_W-1:0]     mul_a, mul_b;
   logic [X_W-1:0]        pp;
   logic [PROD_W-1:0]     pp_shifted;
   logic [PROD_W-1:0]     prod_base;
   logic [ACC_W-1:0]      rnd;
   logic [OUT_W-1:0]      sat_value;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign loop_go  = (count_ff < CNT_W'(MAX_TERMS)) && (|term_ff[X_W-1:OUT_SHIFT]);
   assign stat     = {loop_go, out_free};

   // Magnitude of the incoming angle; the most negative angle maps to 2^31.
   assign ang_u = req_angle;
   assign mag   = ang_u[ANG_W-1] ? (~ang_u + ANG_W'(1)) : ang_u;

   // Restoring reduction subtracts 2*pi shifted down one place per step.
   assign red_shift = 3'(RED_STEPS - 1) - 3'(cmd.step);
   assign red_sub   = TWO_PI_Q48 << red_shift;

   // Shared multiplier: one 28x28 partial product per step.
   assign op_a  = (cmd.op == OP_MUL_SQ) ? x_ff : term_ff;
   assign op_b  = (cmd.op == OP_MUL_SQ) ? x_ff : x2_ff;
   assign mul_a = cmd.step[1] ? op_a[X_W-1:HALF_W] : op_a[HALF_W-1:0];
   assign mul_b = cmd.step[0] ? op_b[X_W-1:HALF_W] : op_b[HALF_W-1:0];
   assign pp    = X_W'(mul_a) * X_W'(mul_b);

   always_comb begin
      case (cmd.step[1:0])
         2'd0:    pp_shifted = PROD_W'(pp);
         2'd3:    pp_shifted = PROD_W'(pp) << (2 * HALF_W);
         default: pp_shifted = PROD_W'(pp) << HALF_W;
      endcase
   end

   assign prod_base = (cmd.step == '0) ? '0 : prod_ff;

   // Rounding to Q2.30 with saturation at both ends.
   assign rnd = acc_ff + ROUND_Q48;
   always_comb begin
      if (rnd[ACC_W-1:OUT_SHIFT+OUT_W-1] == {(ACC_W-OUT_SHIFT-OUT_W+1){rnd[ACC_W-1]}}) begin
         sat_value = rnd[OUT_SHIFT+OUT_W-1:OUT_SHIFT];
      end else if (rnd[ACC_W-1]) begin
         sat_value = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(OUT_W-1){1'b1}}};
      end
   end

   // Next values of all datapath registers.
   always_comb begin
      logic [DIV_W-1:0] rem_v;
      logic [QUO_W-1:0] q_v;
      logic [DIV_W:0]   trial;
      logic [DIV_BITS-1:0] qbits;

      is_cos_in    = is_cos_ff;
      neg_in       = neg_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      term_in      = term_ff;
      term_neg_in  = term_neg_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      rem_v = (cmd.step == '0) ? '0 : rem_ff;
      q_v   = (cmd.step == '0) ? prod_ff[PROD_W-1:FRAC_W] : quo_ff;
      trial = '0;
      qbits = '0;

      case (cmd.op)
         OP_LOAD: begin
            is_cos_in = req_type;
            neg_in    = req_angle[ANG_W-1];
            x_in      = {mag, {ANG_FRAC{1'b0}}};
         end
         OP_REDUCE: begin
            if (x_ff >= red_sub) x_in = x_ff - red_sub;
         end
         OP_FIXUP: begin
            // A negative angle with a nonzero remainder folds to 2*pi minus it.
            if (neg_ff && (x_ff != '0)) x_in = TWO_PI_Q48 - x_ff;
         end
         OP_MUL_SQ, OP_MUL_TERM: begin
            prod_in = prod_base + pp_shifted;
         end
         OP_INIT: begin
            x2_in       = prod_ff[X_W+FRAC_W-1:FRAC_W];
            term_in     = is_cos_ff ? ONE_Q48 : x_ff;
            acc_in      = ACC_W'(is_cos_ff ? ONE_Q48 : x_ff);
            term_neg_in = 1'b0;
            count_in    = CNT_W'(1);
         end
         OP_CHECK: begin
            div_in = pair_divisor(count_ff, is_cos_ff);
         end
         OP_DIV: begin
            // Eight quotient bits per step; the remainder stays below the divisor.
            for (int i = 0; i < DIV_BITS; i++) begin
               trial = {rem_v, q_v[QUO_W-1-i]};
               if (trial >= {1'b0, div_ff}) begin
                  rem_v = DIV_W'(trial - {1'b0, div_ff});
                  qbits[DIV_BITS-1-i] = 1'b1;
               end else begin
                  rem_v = trial[DIV_W-1:0];
               end
            end
            rem_in = rem_v;
            quo_in = {q_v[QUO_W-DIV_BITS-1:0], qbits};
         end
         OP_ACCUM: begin
            // Terms alternate in sign and stay below 2^56 in Q48.
            term_in     = quo_ff[X_W-1:0];
            term_neg_in = !term_neg_ff;
            acc_in      = term_neg_ff ? (acc_ff + quo_ff) : (acc_ff - quo_ff);
            count_in    = count_ff + CNT_W'(1);
         end
         OP_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = sat_value;
            end
         end
         default: ;
      endcase
   end

   // Output valid flag is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      is_cos_ff    <= is_cos_in;
      neg_ff       <= neg_in;
      x_ff         <= x_in;
      x2_ff        <= x2_in;
      term_ff      <= term_in;
      term_neg_ff  <= term_neg_in;
      prod_ff      <= prod_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      acc_ff       <= acc_in;
      count_ff     <= count_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule
